>>> rtl/hrhp_pkg.sv
// Shared types and constants for the HTTP request head parser.
`timescale 1ns / 1ps
`default_nettype none
package hrhp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [2:0] out_field;
    logic [7:0] out_byte;
    logic [1:0] out_status;
  } out_item_t;

  // byte classes computed by the front part
  typedef struct packed {
    logic       eos;
    logic [7:0] c;
    logic       upper;
    logic       alpha;
    logic       digit;
    logic       key;
    logic       blank;
    logic       hex_ok;
    logic [3:0] hex_val;
  } cls_item_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] FLD_METHOD = 3'd0;
  localparam logic [2:0] FLD_URL    = 3'd1;
  localparam logic [2:0] FLD_VER    = 3'd2;
  localparam logic [2:0] FLD_NAME   = 3'd3;
  localparam logic [2:0] FLD_VALUE  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_NOMETHOD = 2'd2;

  localparam logic [1:0] PH_METHOD  = 2'd0;
  localparam logic [1:0] PH_URL     = 2'd1;
  localparam logic [1:0] PH_VERSION = 2'd2;
  localparam logic [1:0] PH_HEADERS = 2'd3;

  localparam logic [3:0] U_LEAD = 4'd0;
  localparam logic [3:0] U_BODY = 4'd1;
  localparam logic [3:0] U_HEX1 = 4'd2;
  localparam logic [3:0] U_HEX2 = 4'd3;

  localparam logic [3:0] H_START    = 4'd0;
  localparam logic [3:0] H_BLANK_CR = 4'd1;
  localparam logic [3:0] H_WS_LINE  = 4'd2;
  localparam logic [3:0] H_NAME     = 4'd3;
  localparam logic [3:0] H_ASSIGN   = 4'd4;
  localparam logic [3:0] H_VALUE_WS = 4'd5;
  localparam logic [3:0] H_VALUE    = 4'd6;
  localparam logic [3:0] H_LINE_CR  = 4'd7;
  localparam logic [3:0] S_HALT     = 4'd15;

  localparam logic [20:0] LIMIT_MIN   = 21'd128;
  localparam logic [20:0] LIMIT_MAX   = 21'd1048960;
  localparam logic [20:0] LIMIT_RESET = 21'd4096;
  localparam logic [7:0]  URL_MAX     = 8'd126;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  function automatic logic [7:0] get_char(input logic [2:0] pos);
    case (pos)
      3'd0:    get_char = 8'h47;
      3'd1:    get_char = 8'h45;
      default: get_char = 8'h54;
    endcase
  endfunction

  function automatic logic [7:0] http_char(input logic [2:0] pos);
    case (pos)
      3'd0:    http_char = 8'h48;
      3'd1:    http_char = 8'h54;
      3'd2:    http_char = 8'h54;
      3'd3:    http_char = 8'h50;
      default: http_char = 8'h2F;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/http_request_head_parser.sv
// Top level of the HTTP request head parser.
// Each accepted byte is classified into the front register; its result is then registered in the output register.
// Throughput: one byte per cycle while out_stall is low; classify stage and parser stage each hold one item.
// Reset (rst_n, synchronous): parser back to the method phase, field limit 4096,
// both stages empty. After completion or an error the parser stays halted until reset.
`timescale 1ns / 1ps
`default_nettype none
module http_request_head_parser
  import hrhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [20:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  logic      cls_valid;
  logic      cls_stall;
  cls_item_t cls_data;

  hrhp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cls_valid, .cls_stall, .cls_data
  );

  hrhp_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .cls_valid, .cls_stall, .cls_data,
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

>>> rtl/hrhp_front.sv
// Front part: accepts bytes, classifies them and registers the result.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_front
  import hrhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           cls_valid,
  input  wire logic      cls_stall,
  output cls_item_t      cls_data
);

  logic      valid_r, valid_nxt;
  cls_item_t data_r, data_nxt;
  logic      take;
  logic [7:0] c;

  assign in_stall  = valid_r && cls_stall;
  assign take      = in_valid && !in_stall;
  assign cls_valid = valid_r;
  assign cls_data  = data_r;
  assign c         = in_data.in_byte;

  always_comb begin
    data_nxt = data_r;
    valid_nxt = valid_r && cls_stall;
    if (take) begin
      valid_nxt = 1'b1;
      data_nxt.eos   = in_data.stream_end;
      data_nxt.c     = c;
      data_nxt.upper = (c >= 8'h41 && c <= 8'h5A);
      data_nxt.alpha = data_nxt.upper || (c >= 8'h61 && c <= 8'h7A);
      data_nxt.digit = (c >= 8'h30 && c <= 8'h39);
      data_nxt.key   = data_nxt.alpha || data_nxt.digit || c == 8'h2D;
      data_nxt.blank = (c == CH_SP) || (c == CH_TAB);
      data_nxt.hex_ok = 1'b1;
      if (data_nxt.digit) data_nxt.hex_val = c[3:0];
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        data_nxt.hex_val = 4'(c[3:0] + 4'd9);
      else begin
        data_nxt.hex_ok = 1'b0;
        data_nxt.hex_val = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/hrhp_back.sv
// Back part: parser state machine and registered result output.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_back
  import hrhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [20:0] cfg_wdata,
  input  wire logic        cls_valid,
  output logic             cls_stall,
  input  wire cls_item_t   cls_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  logic [20:0] limit_r, lim_c;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  sub_r, sub_nxt;
  logic [20:0] count_r, count_nxt;
  logic [3:0]  hexh_r, hexh_nxt;
  logic [2:0]  tpos_r, tpos_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;
  logic        go;
  logic        emit;
  out_item_t   res;
  logic [7:0]  c;
  logic [7:0]  ub;
  logic        ud;

  assign cls_stall = ov_r && out_stall;
  assign go        = cls_valid && !cls_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign c         = cls_data.c;

  always_comb begin
    lim_c = limit_r;
    if (limit_r < LIMIT_MIN) lim_c = LIMIT_MIN;
    if (limit_r > LIMIT_MAX) lim_c = LIMIT_MAX;
  end

  always_comb begin
    phase_nxt = phase_r; sub_nxt = sub_r; count_nxt = count_r;
    hexh_nxt = hexh_r; tpos_nxt = tpos_r; flags_nxt = flags_r;
    emit = 1'b0;
    res = '0;
    ub = c;
    ud = 1'b0;
    if (go && sub_r != S_HALT) begin
      emit = 1'b1;
      if (cls_data.eos) begin
        res = '{KIND_ERROR, 3'd0, 8'd0, ST_BAD};
        if (phase_r != PH_HEADERS) res.out_field = {1'b0, phase_r};
        else if (sub_r == H_VALUE_WS || sub_r == H_VALUE) res.out_field = FLD_VALUE;
        else res.out_field = FLD_NAME;
        sub_nxt = S_HALT;
      end else begin
        unique case (phase_r)
          PH_METHOD: begin
            if (c == CH_SP) begin
              if (flags_r[0] || tpos_r != 3'd3)
                res = '{KIND_ERROR, FLD_METHOD, c, ST_NOMETHOD};
              else begin
                res = '{KIND_END, FLD_METHOD, 8'd0, ST_OK};
                phase_nxt = PH_URL; sub_nxt = U_LEAD; count_nxt = '0; flags_nxt = '0;
              end
            end else if (!cls_data.upper) res = '{KIND_ERROR, FLD_METHOD, c, ST_BAD};
            else begin
              if (tpos_r < 3'd3 && c == get_char(tpos_r)) tpos_nxt = 3'(tpos_r + 3'd1);
              else flags_nxt[0] = 1'b1;
              res = '{KIND_DATA, FLD_METHOD, c, ST_OK};
            end
          end
          PH_URL: begin
            if (sub_r == U_LEAD || sub_r == U_BODY) begin
              if (sub_r == U_LEAD && c == CH_SP) emit = 1'b0;
              else begin
                sub_nxt = U_BODY;
                if (c == CH_PLUS) begin ud = 1'b1; ub = CH_SP; end
                else if (c == CH_PCT) begin sub_nxt = U_HEX1; emit = 1'b0; end
                else if (c == CH_SP) begin
                  if (!flags_r[1]) res = '{KIND_ERROR, FLD_URL, c, ST_BAD};
                  else begin
                    res = '{KIND_END, FLD_URL, 8'd0, ST_OK};
                    phase_nxt = PH_VERSION; sub_nxt = 4'd0; count_nxt = '0;
                    tpos_nxt = '0;
                  end
                end else if (c > CH_SP && c <= URL_MAX) ud = 1'b1;
                else res = '{KIND_ERROR, FLD_URL, c, ST_BAD};
              end
            end else if (!cls_data.hex_ok) res = '{KIND_ERROR, FLD_URL, c, ST_BAD};
            else if (sub_r == U_HEX1) begin
              hexh_nxt = cls_data.hex_val; sub_nxt = U_HEX2; emit = 1'b0;
            end else begin
              sub_nxt = U_BODY; ud = 1'b1; ub = {hexh_r, cls_data.hex_val};
            end
            if (ud) begin
              flags_nxt[1] = 1'b1;
              if (!flags_r[1] && ub != CH_SLASH) begin
                res = '{KIND_ERROR, FLD_URL, ub, ST_BAD}; ud = 1'b0;
              end else res = '{KIND_DATA, FLD_URL, ub, ST_OK};
            end
          end
          PH_VERSION: begin
            if (tpos_r < 3'd5) begin
              if (c != http_char(tpos_r)) res = '{KIND_ERROR, FLD_VER, c, ST_BAD};
              else begin
                tpos_nxt = 3'(tpos_r + 3'd1);
                res = '{KIND_DATA, FLD_VER, c, ST_OK};
              end
            end else if (tpos_r == 3'd5 && (cls_data.digit || c == CH_DOT))
              res = '{KIND_DATA, FLD_VER, c, ST_OK};
            else if (tpos_r == 3'd5 && c == CH_CR) begin
              tpos_nxt = 3'd6; emit = 1'b0;
            end else if (c == CH_LF) begin
              res = '{KIND_END, FLD_VER, 8'd0, ST_OK};
              phase_nxt = PH_HEADERS; sub_nxt = H_START; count_nxt = '0;
            end else res = '{KIND_ERROR, FLD_VER, c, ST_BAD};
          end
          default: begin
            res = '{KIND_ERROR, FLD_NAME, c, ST_BAD};
            case (sub_r)
              H_START, H_WS_LINE: begin
                if (sub_r == H_START && c == CH_CR) begin
                  sub_nxt = H_BLANK_CR; emit = 1'b0;
                end else if (sub_r == H_START && c == CH_LF) begin
                  sub_nxt = S_HALT; res = '{KIND_DONE, 3'd0, 8'd0, ST_OK};
                end else if (cls_data.blank) begin sub_nxt = H_WS_LINE; emit = 1'b0; end
                else if (c == CH_CR) begin sub_nxt = H_LINE_CR; emit = 1'b0; end
                else if (c == CH_LF) begin
                  sub_nxt = H_START; count_nxt = '0; emit = 1'b0;
                end else if (cls_data.alpha) begin
                  sub_nxt = H_NAME; res = '{KIND_DATA, FLD_NAME, c, ST_OK};
                end
              end
              H_BLANK_CR:
                if (c == CH_LF) begin
                  sub_nxt = S_HALT; res = '{KIND_DONE, 3'd0, 8'd0, ST_OK};
                end
              H_NAME: begin
                if (cls_data.key) res = '{KIND_DATA, FLD_NAME, c, ST_OK};
                else if (cls_data.blank) begin
                  sub_nxt = H_ASSIGN; res = '{KIND_END, FLD_NAME, 8'd0, ST_OK};
                end else if (c == CH_COLON) begin
                  sub_nxt = H_VALUE_WS; res = '{KIND_END, FLD_NAME, 8'd0, ST_OK};
                end
              end
              H_ASSIGN: begin
                if (cls_data.blank) emit = 1'b0;
                else if (c == CH_COLON) begin sub_nxt = H_VALUE_WS; emit = 1'b0; end
              end
              H_VALUE_WS, H_VALUE: begin
                if (sub_r == H_VALUE_WS && cls_data.blank) emit = 1'b0;
                else if (c == CH_CR) begin
                  sub_nxt = H_LINE_CR; res = '{KIND_END, FLD_VALUE, 8'd0, ST_OK};
                end else if (c == CH_LF) begin
                  sub_nxt = H_START; count_nxt = '0;
                  res = '{KIND_END, FLD_VALUE, 8'd0, ST_OK};
                end else begin
                  sub_nxt = H_VALUE; res = '{KIND_DATA, FLD_VALUE, c, ST_OK};
                end
              end
              H_LINE_CR:
                if (c == CH_LF) begin
                  sub_nxt = H_START; count_nxt = '0; emit = 1'b0;
                end
              default: emit = 1'b0;
            endcase
          end
        endcase
        if (emit && res.out_kind == KIND_DATA) begin
          if (count_r >= 21'(lim_c - 21'd2)) res.out_kind = KIND_ERROR;
          else count_nxt = 21'(count_r + 21'd1);
          if (res.out_kind == KIND_ERROR) res.out_status = ST_BAD;
        end
        if (emit && res.out_kind == KIND_ERROR) sub_nxt = S_HALT;
      end
    end
    ov_nxt = (ov_r && out_stall) || emit;
    od_nxt = emit ? res : od_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      phase_r <= PH_METHOD; sub_r <= 4'd0; count_r <= '0;
      hexh_r <= '0; tpos_r <= '0; flags_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      phase_r <= phase_nxt; sub_r <= sub_nxt; count_r <= count_nxt;
      hexh_r <= hexh_nxt; tpos_r <= tpos_nxt; flags_r <= flags_nxt; ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end

endmodule
`default_nettype wire

>>> tb/http_request_head_parser_chk.sv
// Checker for the HTTP request head parser: predicts each result and compares.
`timescale 1ns / 1ps
module http_request_head_parser_chk
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int          errors,
  output int          pending,
  output int          seen
);

  localparam logic [23:0] GET_WORD  = "GET";
  localparam logic [39:0] HTTP_WORD = "HTTP/";

  // parser state
  logic [20:0] limit_reg;
  logic [1:0]  phase;
  logic [3:0]  sub;
  int unsigned count;
  logic [3:0]  hex_hi;
  logic [2:0]  tpos;
  bit          method_bad;
  bit          url_seen;

  out_item_t   want_q[$];

  function automatic out_item_t mk(logic [1:0] k, logic [2:0] f, logic [7:0] b,
                                   logic [1:0] s);
    out_item_t r;
    r.out_kind = k; r.out_field = f; r.out_byte = b; r.out_status = s;
    return r;
  endfunction

  function automatic out_item_t halt_err(logic [2:0] f, logic [7:0] b, logic [1:0] s);
    sub = S_HALT;
    return mk(KIND_ERROR, f, b, s);
  endfunction

  function automatic out_item_t put_data(logic [2:0] f, logic [7:0] b);
    int unsigned lim;
    lim = 32'(limit_reg);
    if (lim < LIMIT_MIN) lim = 32'(LIMIT_MIN);
    if (lim > LIMIT_MAX) lim = 32'(LIMIT_MAX);
    if (count >= lim - 2) return halt_err(f, b, ST_BAD);
    count++;
    return mk(KIND_DATA, f, b, ST_OK);
  endfunction

  function automatic out_item_t url_data(logic [7:0] b);
    if (!url_seen) begin
      url_seen = 1;
      if (b != CH_SLASH) return halt_err(FLD_URL, b, ST_BAD);
    end
    return put_data(FLD_URL, b);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic out_item_t end_version();
    phase = PH_HEADERS; sub = H_START; count = 0;
    return mk(KIND_END, FLD_VER, 8'd0, ST_OK);
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit parse_item(input in_item_t it, output out_item_t r);
    logic [7:0] c;
    logic [2:0] ef;
    logic [3:0] st;
    int h;
    c = it.in_byte;
    r = '0;
    if (sub == S_HALT) return 0;
    if (it.stream_end) begin
      if (phase != PH_HEADERS) ef = {1'b0, phase};
      else ef = (sub == H_VALUE_WS || sub == H_VALUE) ? FLD_VALUE : FLD_NAME;
      r = halt_err(ef, 8'd0, ST_BAD);
      return 1;
    end
    case (phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          if (method_bad || tpos != 3'd3) r = halt_err(FLD_METHOD, c, ST_NOMETHOD);
          else begin
            phase = PH_URL; sub = U_LEAD; count = 0; method_bad = 0; url_seen = 0;
            r = mk(KIND_END, FLD_METHOD, 8'd0, ST_OK);
          end
          return 1;
        end
        if (c < "A" || c > "Z") begin
          r = halt_err(FLD_METHOD, c, ST_BAD);
          return 1;
        end
        if (tpos < 3'd3 && c == GET_WORD[23 - 8 * tpos -: 8]) tpos++;
        else method_bad = 1;
        r = put_data(FLD_METHOD, c);
        return 1;
      end
      PH_URL: begin
        if (sub == U_LEAD) begin
          if (c == CH_SP) return 0;
          sub = U_BODY;
        end
        if (sub == U_BODY) begin
          if (c == CH_PLUS) r = url_data(CH_SP);
          else if (c == CH_PCT) begin
            sub = U_HEX1;
            return 0;
          end else if (c == CH_SP) begin
            if (!url_seen) r = halt_err(FLD_URL, c, ST_BAD);
            else begin
              phase = PH_VERSION; sub = 4'd0; count = 0; tpos = 3'd0;
              r = mk(KIND_END, FLD_URL, 8'd0, ST_OK);
            end
          end else if (c > CH_SP && c <= URL_MAX) r = url_data(c);
          else r = halt_err(FLD_URL, c, ST_BAD);
          return 1;
        end
        h = hex_digit(c);
        if (h < 0) begin
          r = halt_err(FLD_URL, c, ST_BAD);
          return 1;
        end
        if (sub == U_HEX1) begin
          hex_hi = h[3:0];
          sub = U_HEX2;
          return 0;
        end
        sub = U_BODY;
        r = url_data({hex_hi, h[3:0]});
        return 1;
      end
      PH_VERSION: begin
        if (tpos < 3'd5) begin
          if (c != HTTP_WORD[39 - 8 * tpos -: 8]) r = halt_err(FLD_VER, c, ST_BAD);
          else begin
            tpos++;
            r = put_data(FLD_VER, c);
          end
          return 1;
        end
        if (tpos == 3'd5) begin
          if ((c >= "0" && c <= "9") || c == CH_DOT) r = put_data(FLD_VER, c);
          else if (c == CH_CR) begin
            tpos = 3'd6;
            return 0;
          end else if (c == CH_LF) r = end_version();
          else r = halt_err(FLD_VER, c, ST_BAD);
          return 1;
        end
        if (c == CH_LF) r = end_version();
        else r = halt_err(FLD_VER, c, ST_BAD);
        return 1;
      end
      default: begin
        st = sub;
        if (st == H_START) begin
          if (c == CH_CR) begin
            sub = H_BLANK_CR;
            return 0;
          end
          if (c == CH_LF) begin
            sub = S_HALT;
            r = mk(KIND_DONE, 3'd0, 8'd0, ST_OK);
            return 1;
          end
          st = H_WS_LINE;
        end
        if (st == H_VALUE_WS) begin
          if (is_blank(c)) return 0;
          st = H_VALUE;
        end
        case (st)
          H_WS_LINE: begin
            if (is_blank(c)) begin
              sub = H_WS_LINE;
              return 0;
            end
            if (c == CH_CR) begin
              sub = H_LINE_CR;
              return 0;
            end
            if (c == CH_LF) begin
              sub = H_START; count = 0;
              return 0;
            end
            if (is_alpha(c)) begin
              sub = H_NAME;
              r = put_data(FLD_NAME, c);
            end else r = halt_err(FLD_NAME, c, ST_BAD);
            return 1;
          end
          H_BLANK_CR: begin
            if (c == CH_LF) begin
              sub = S_HALT;
              r = mk(KIND_DONE, 3'd0, 8'd0, ST_OK);
            end else r = halt_err(FLD_NAME, c, ST_BAD);
            return 1;
          end
          H_NAME: begin
            if (is_alpha(c) || (c >= "0" && c <= "9") || c == "-")
              r = put_data(FLD_NAME, c);
            else if (is_blank(c)) begin
              sub = H_ASSIGN;
              r = mk(KIND_END, FLD_NAME, 8'd0, ST_OK);
            end else if (c == CH_COLON) begin
              sub = H_VALUE_WS;
              r = mk(KIND_END, FLD_NAME, 8'd0, ST_OK);
            end else r = halt_err(FLD_NAME, c, ST_BAD);
            return 1;
          end
          H_ASSIGN: begin
            if (is_blank(c)) return 0;
            if (c == CH_COLON) begin
              sub = H_VALUE_WS;
              return 0;
            end
            r = halt_err(FLD_NAME, c, ST_BAD);
            return 1;
          end
          H_VALUE: begin
            if (c == CH_CR) begin
              sub = H_LINE_CR;
              r = mk(KIND_END, FLD_VALUE, 8'd0, ST_OK);
            end else if (c == CH_LF) begin
              sub = H_START; count = 0;
              r = mk(KIND_END, FLD_VALUE, 8'd0, ST_OK);
            end else begin
              sub = H_VALUE;
              r = put_data(FLD_VALUE, c);
            end
            return 1;
          end
          H_LINE_CR: begin
            if (c == CH_LF) begin
              sub = H_START; count = 0;
              return 0;
            end
            r = halt_err(FLD_NAME, c, ST_BAD);
            return 1;
          end
          default: return 0;
        endcase
      end
    endcase
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    seen = 0;
  end

  always @(posedge clk) begin
    out_item_t r, w;
    bit has;
    if (!rst_n) begin
      limit_reg = LIMIT_RESET;
      phase = PH_METHOD; sub = 4'd0; count = 0; hex_hi = 4'd0; tpos = 3'd0;
      method_bad = 0; url_seen = 0;
      want_q.delete();
    end else begin
      if (cfg_we) limit_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        has = parse_item(in_data, r);
        if (has) want_q.push_back(r);
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: kind %0d field %0d byte %h status %0d",
                     out_data.out_kind, out_data.out_field, out_data.out_byte,
                     out_data.out_status);
        end else begin
          w = want_q.pop_front();
          if (out_data.out_kind !== w.out_kind || out_data.out_field !== w.out_field ||
              out_data.out_byte !== w.out_byte || out_data.out_status !== w.out_status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: expected k%0d f%0d b%h s%0d, got k%0d f%0d b%h s%0d",
                       seen, w.out_kind, w.out_field, w.out_byte, w.out_status,
                       out_data.out_kind, out_data.out_field, out_data.out_byte,
                       out_data.out_status);
          end
        end
      end
    end
    pending = want_q.size();
  end

endmodule

>>> tb/http_request_head_parser_tb.sv
// Testbench top for the HTTP request head parser: stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module http_request_head_parser_tb;
  import hrhp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [20:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  int errors, pending, seen;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  bit hold_req = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  int items_sent = 0;
  int limit_writes = 0;

  always #5 clk = ~clk;

  http_request_head_parser dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  http_request_head_parser_chk chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending), .seen(seen)
  );

  // receiver: stall pattern changes every so often; a long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cycles = 400;
      hold_req = 0;
    end
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_tick % 5 < 3);
      endcase
    end
  end

  task automatic send_item(input logic [7:0] b, input bit last);
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, stream_end: last};
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // wait for the block to drain, then write the field limit
  task automatic set_limit(input logic [20:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_writes++;
  endtask

  task automatic send_header_line(input int max_value);
    int nl, vl, r;
    logic [7:0] b;
    r = $urandom_range(0, 25);
    send_item($urandom_range(0, 1) ? 8'(8'h41 + r) : 8'(8'h61 + r), 1'b0);
    nl = $urandom_range(0, 7);
    for (int i = 0; i < nl; i++) begin
      r = $urandom_range(0, 63);
      if (r < 26) b = 8'(8'h41 + r);
      else if (r < 52) b = 8'(8'h61 + r - 26);
      else if (r < 62) b = 8'(8'h30 + r - 52);
      else b = "-";
      send_item(b, 1'b0);
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_item($urandom_range(0, 1) ? CH_SP : CH_TAB, 1'b0);
    send_item(CH_COLON, 1'b0);
    repeat ($urandom_range(0, 2)) send_item(CH_SP, 1'b0);
    vl = $urandom_range(0, max_value);
    for (int i = 0; i < vl; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_CR || b == CH_LF) b = 8'hFF;
      send_item(b, 1'b0);
    end
    if ($urandom_range(0, 1)) send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
  endtask

  initial begin
    int ending, guard;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // below the minimum, clamps to 128
    set_limit(21'd0);

    // directed: leading blanks, plus, upper and lower hex, CR LF version
    send_str("GET   /a+b%2f%4a%7E~x?q=1 HTTP/1.1");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_str("Host: x");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_str("Ab-9 \t:\tv");
    send_item(CH_LF, 1'b0);
    send_str("E:");
    send_item(CH_LF, 1'b0);
    send_str(" \t ");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    set_limit(21'd128);

    for (int line = 0; line < 48; line++) begin
      if (line == 20) hold_req = 1;
      if (line % 8 == 7) begin
        case ((line / 8) % 5)
          0: set_limit(21'h1FFFFF);
          1: set_limit(LIMIT_MAX);
          2: set_limit(21'd129);
          3: set_limit(LIMIT_RESET);
          default: set_limit(21'($urandom_range(128, 2000)));
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(CH_SP, 1'b0);
        send_item(CH_LF, 1'b0);
      end else send_header_line(40);
    end

    // one terminal event per run
    ending = $urandom_range(0, 5);
    case (ending)
      0: begin
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end
      1: send_item(CH_LF, 1'b0);
      2: begin
        send_str("Xy: ab");
        send_item(8'h00, 1'b1);
      end
      3: begin
        set_limit(21'd128);
        send_str("Long:");
        repeat (140) send_item("z", 1'b0);
      end
      4: send_str("Bad@");
      default: begin
        send_item(CH_CR, 1'b0);
        send_item("x", 1'b0);
      end
    endcase
    // halted: these give nothing
    repeat (8) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_item(8'hA5, 1'b1);
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d items, %0d results, %0d limit writes, ending case %0d",
             items_sent, seen, limit_writes, ending);
    $display("request: GET, decoded URL, version, header lines, receiver hold-off");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
